// File: rtl/psrs_pkg.sv
`default_nettype none
package psrs_pkg;
  localparam int unsigned DefaultMaxComponents = 128;
  localparam int unsigned CompW = 7;
  localparam int unsigned ThreshW = 16;
  localparam logic [ThreshW-1:0] ThreshReset = 16'd7;

  typedef enum logic [1:0] {
    ACT_VAR = 2'd0,
    ACT_WEIGHT = 2'd1,
    ACT_ELEM = 2'd2,
    ACT_SCORE = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0] action;
    logic [CompW-1:0] component;
    logic signed [31:0] value;
    logic signed [31:0] average;
    logic first_element;
    logic last_element;
  } in_item_t;

  typedef struct packed {
    logic kind;
    logic signed [31:0] result;
    logic saturated;
  } out_item_t;

  localparam logic signed [63:0] S64Max = 64'sh7fffffffffffffff;
  localparam logic signed [63:0] S64Min = 64'sh8000000000000000;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return S64Max;
    if (a[63] && b[63] && !s[63]) return S64Min;
    return s;
  endfunction
endpackage
`default_nettype wire

// File: rtl/psrs_if.sv
`default_nettype none
interface psrs_in_if;
  logic valid;
  logic ready;
  psrs_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface psrs_out_if;
  logic valid;
  logic ready;
  psrs_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/psrs_divider.sv
`default_nettype none
module psrs_divider (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic [63:0] dividend,
  input wire logic [31:0] divisor,
  output logic done,
  output logic [63:0] quotient
);
  logic busy;
  logic [6:0] count;
  logic [63:0] q;
  logic [32:0] rem;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem[31:0], q[63]};
  assign trial = shifted - {1'b0, divisor};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= !start && busy && count == 7'd1;
      if (start) begin
        busy <= 1'b1;
        count <= 7'd64;
        q <= dividend;
        rem <= '0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          q <= {q[62:0], 1'b1};
        end else begin
          rem <= shifted;
          q <= {q[62:0], 1'b0};
        end
        count <= count - 7'd1;
        if (count == 7'd1) busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/psrs_front.sv
`default_nettype none
module psrs_front #(
  parameter int unsigned Depth = 2
) (
  input wire logic clk,
  input wire logic rst,
  psrs_in_if.sink in_ch,
  output logic q_valid,
  output psrs_pkg::in_item_t q_data,
  input wire logic q_pop
);
  import psrs_pkg::*;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  in_item_t mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic push;

  assign in_ch.ready = cnt != (AW+1)'(Depth);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = cnt != '0;
  assign q_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_ch.data;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(Depth-1)) ? '0 : wp + AW'(1);
      if (q_pop) rp <= (rp == AW'(Depth-1)) ? '0 : rp + AW'(1);
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end
endmodule
`default_nettype wire

// File: rtl/psrs_back.sv
`default_nettype none
module psrs_back #(
  parameter int unsigned MaxComponents = 128
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic [psrs_pkg::ThreshW-1:0] thresh,
  input wire logic q_valid,
  input wire psrs_pkg::in_item_t q_data,
  output logic q_pop,
  psrs_out_if.source out_ch
);
  import psrs_pkg::*;
  localparam int unsigned IW = (MaxComponents > 1) ? $clog2(MaxComponents) : 1;
  localparam int unsigned NW = $clog2(MaxComponents + 1);
  localparam logic [31:0] RecipLo = 32'hCCCCCCCD;
  localparam logic [31:0] RecipHi = 32'hCCCCCCCC;

  typedef enum logic [3:0] {
    S_IDLE, S_ELEM_RD, S_ELEM_MUL, S_SC_RD, S_SC_MUL, S_SC_DIV, S_SC_ABS, S_SC_RECIP,
    S_SC_FIN, S_OUT
  } state_t;
  state_t state;

  logic signed [31:0] weights [MaxComponents];
  logic [MaxComponents-1:0] wvalid;
  logic signed [31:0] variances [MaxComponents];

  logic signed [63:0] acc;
  logic signed [63:0] sum;
  logic [NW-1:0] idx;
  logic signed [31:0] wr, vr;
  logic wrv;
  in_item_t cur;
  logic signed [63:0] prod;
  logic elem_add;
  logic signed [63:0] elem_sum;
  logic [63:0] sq;
  logic [31:0] vmag;
  logic vneg;
  logic div_start, div_done;
  logic [63:0] div_q;
  logic in_table;
  logic [31:0] wmag;
  logic [31:0] wsel;
  logic [63:0] wsq;
  logic [63:0] tmp64;
  logic signed [63:0] base;
  logic signed [63:0] rs;
  logic signed [63:0] sc;
  logic [63:0] qmag;
  logic [63:0] qmag_r;
  logic [127:0] qacc;
  logic [1:0] rstep;
  logic [31:0] pa, pc;
  logic [63:0] pp;
  logic [127:0] pp_sh;

  assign in_table = 32'(q_data.component) < MaxComponents;

  psrs_divider u_div (
    .clk, .rst, .start(div_start), .dividend(sq), .divisor(vmag),
    .done(div_done), .quotient(div_q)
  );

  always_comb begin
    wmag = wr[31] ? 32'(-wr) : wr;
    wsel = wvalid[idx[IW-1:0]] ? wmag : 32'd0;
    wsq = wsel * wsel;
    base = cur.first_element ? (64'(cur.average) <<< 16) : acc;
    prod = $signed(wr) * $signed(cur.value);
    elem_add = wrv && wr != 0 && wmag >= 32'(thresh);
    elem_sum = elem_add ? sat_add64(base, prod) : base;
    rs = elem_sum >>> 16;
    qmag = sum[63] ? 64'(-sum) : sum;
    pa = rstep[1] ? qmag_r[63:32] : qmag_r[31:0];
    pc = rstep[0] ? RecipHi : RecipLo;
    pp = pa * pc;
    case (rstep)
      2'd0: pp_sh = {64'd0, pp};
      2'd3: pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    tmp64 = {3'd0, qacc[127:67]};
    sc = 64'sd655360 - (sum[63] ? -$signed(tmp64) : $signed(tmp64));
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.action == ACT_WEIGHT && in_table)
      weights[IW'(q_data.component)] <= q_data.value;
    if (q_pop && q_data.action == ACT_VAR && in_table)
      variances[IW'(q_data.component)] <= q_data.value;
    if (state == S_ELEM_RD || state == S_SC_RD) begin
      wr <= weights[idx[IW-1:0]];
      vr <= variances[idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    q_pop <= !rst && state == S_IDLE && q_valid && !q_pop;
    div_start <= !rst && state == S_SC_MUL && vr != 0;
    if (rst) begin
      state <= S_IDLE;
      wvalid <= '0;
      acc <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid && !q_pop) begin
            cur <= q_data;
            unique case (action_t'(q_data.action))
              ACT_VAR: ;
              ACT_WEIGHT: begin
                if (in_table) wvalid[IW'(q_data.component)] <= 1'b1;
              end
              ACT_ELEM: begin
                idx <= NW'(q_data.component);
                wrv <= in_table && wvalid[IW'(q_data.component)];
                state <= S_ELEM_RD;
              end
              ACT_SCORE: begin
                sum <= '0;
                idx <= '0;
                state <= S_SC_RD;
              end
              default: ;
            endcase
          end
        end
        S_ELEM_RD: state <= S_ELEM_MUL;
        S_ELEM_MUL: begin
          acc <= elem_sum;
          if (cur.last_element) begin
            out_ch.data.kind <= 1'b0;
            if (rs > 64'sd2147483647) begin
              out_ch.data.result <= 32'sh7fffffff; out_ch.data.saturated <= 1'b1;
            end else if (rs < -64'sd2147483648) begin
              out_ch.data.result <= 32'sh80000000; out_ch.data.saturated <= 1'b1;
            end else begin
              out_ch.data.result <= rs[31:0]; out_ch.data.saturated <= 1'b0;
            end
            out_ch.valid <= 1'b1;
            state <= S_OUT;
          end else state <= S_IDLE;
        end
        S_SC_RD: state <= S_SC_MUL;
        S_SC_MUL: begin
          if (vr == 0) begin
            idx <= idx + NW'(1);
            state <= (idx == NW'(MaxComponents-1)) ? S_SC_ABS : S_SC_RD;
          end else begin
            sq <= wsq;
            vmag <= vr[31] ? 32'(-vr) : vr;
            vneg <= vr[31];
            state <= S_SC_DIV;
          end
        end
        S_SC_DIV: begin
          if (div_done) begin
            sum <= sat_add64(sum, vneg ? -$signed(div_q) : $signed(div_q));
            idx <= idx + NW'(1);
            state <= (idx == NW'(MaxComponents-1)) ? S_SC_ABS : S_SC_RD;
          end
        end
        S_SC_ABS: begin
          qmag_r <= qmag;
          qacc <= '0;
          rstep <= '0;
          state <= S_SC_RECIP;
        end
        S_SC_RECIP: begin
          qacc <= qacc + pp_sh;
          rstep <= rstep + 2'd1;
          if (rstep == 2'd3) state <= S_SC_FIN;
        end
        S_SC_FIN: begin
          out_ch.data.kind <= 1'b1;
          if (sc < 0) begin
            out_ch.data.result <= '0; out_ch.data.saturated <= 1'b0;
          end else if (sc > 64'sd2147483647) begin
            out_ch.data.result <= 32'sh7fffffff; out_ch.data.saturated <= 1'b1;
          end else begin
            out_ch.data.result <= sc[31:0]; out_ch.data.saturated <= 1'b0;
          end
          out_ch.valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/pca_shape_reconstruct_score_top.sv
`default_nettype none
// channel   dir  payload
// in_ch     in   action, component, value, average, first_element, last_element
// out_ch    out  kind, result, saturated
// Set/load: S_IDLE only. Element: S_ELEM_RD, S_ELEM_MUL, S_OUT if it emits.
// Score: S_SC_RD, S_SC_MUL per component, S_SC_DIV (64-step divider) if the
// variance is nonzero; S_SC_ABS/RECIP/FIN scale by 1/10; S_OUT presents it.
// rst synchronous: clears weight valid bits, accumulator, threshold to 7.
// A two-entry queue decouples intake; a stalled out_ch holds the back end and
// the queue then fills and drops in_ch.ready.
module pca_shape_reconstruct_score_top #(
  parameter int unsigned MaxComponents = psrs_pkg::DefaultMaxComponents
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic [psrs_pkg::ThreshW-1:0] cfg_wdata,
  psrs_in_if.sink in_ch,
  psrs_out_if.source out_ch
);
  import psrs_pkg::*;
  logic [ThreshW-1:0] thresh;
  logic q_valid, q_pop;
  in_item_t q_data;

  always_ff @(posedge clk) begin
    if (rst) thresh <= ThreshReset;
    else if (cfg_we) thresh <= cfg_wdata;
  end

  psrs_front #(.Depth(2)) u_front (.clk, .rst, .in_ch, .q_valid, .q_data, .q_pop);
  psrs_back #(.MaxComponents(MaxComponents)) u_back (
    .clk, .rst, .thresh, .q_valid, .q_data, .q_pop, .out_ch
  );

  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("output dropped");
endmodule
`default_nettype wire

// File: tb/pca_shape_reconstruct_score_top_test.sv
`default_nettype none
module pca_shape_reconstruct_score_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import psrs_pkg::*;

  localparam int NumComp = DefaultMaxComponents;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ThreshW-1:0] cfg_wdata = '0;

  psrs_in_if in_ch();
  psrs_out_if out_ch();

  pca_shape_reconstruct_score_top u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #2 clk = ~clk;

  // shadow of the block's state
  logic signed [31:0] weight_tab [NumComp];
  logic signed [31:0] variance_tab [NumComp];
  longint coord_acc;
  logic [ThreshW-1:0] skip_thr;
  out_item_t pending_results[$];
  int fails = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_cycles = 0;
  int hold_req = 0;
  int hold_ack = 0;

  function automatic longint add_sat(longint a, longint b);
    longint s;
    s = a + b;
    if (a >= 0 && b >= 0 && s < 0) return 64'sh7fffffffffffffff;
    if (a < 0 && b < 0 && s >= 0) return 64'sh8000000000000000;
    return s;
  endfunction

  function automatic out_item_t clip_result(logic kind, longint v);
    out_item_t o;
    o.kind = kind;
    o.saturated = 1'b0;
    if (v > 64'sd2147483647) begin
      o.result = 32'sh7fffffff;
      o.saturated = 1'b1;
    end else if (v < -64'sd2147483648) begin
      o.result = 32'sh80000000;
      o.saturated = 1'b1;
    end else begin
      o.result = v[31:0];
    end
    return o;
  endfunction

  function automatic void reconstruct(in_item_t it);
    longint w, wmag, s, vr;
    longint unsigned wm, vm, t;
    case (it.action)
      ACT_VAR: variance_tab[it.component] = it.value;
      ACT_WEIGHT: weight_tab[it.component] = it.value;
      ACT_ELEM: begin
        w = weight_tab[it.component];
        wmag = w < 0 ? -w : w;
        if (it.first_element) coord_acc = longint'(it.average) * 64'sd65536;
        if (w != 0 && wmag >= longint'({48'b0, skip_thr}))
          coord_acc = add_sat(coord_acc, w * longint'(it.value));
        if (it.last_element)
          pending_results.insert(pending_results.size(), clip_result(1'b0, coord_acc >>> 16));
      end
      default: begin
        s = 0;
        for (int i = 0; i < NumComp; i++) begin
          vr = variance_tab[i];
          if (vr == 0) continue;
          w = weight_tab[i];
          wm = w < 0 ? -w : w;
          vm = vr < 0 ? -vr : vr;
          t = (wm * wm) / vm;
          s = add_sat(s, vr < 0 ? -longint'(t) : longint'(t));
        end
        s = 64'sd655360 - s / 10;
        if (s < 0) s = 0;
        pending_results.insert(pending_results.size(), clip_result(1'b1, s));
      end
    endcase
  endfunction

  task automatic send_item(in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    reconstruct(it);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_op(action_t a, int comp, logic [31:0] v, logic [31:0] avg = '0,
                         bit first = 1'b0, bit last = 1'b0);
    in_item_t it;
    it.action = a;
    it.component = comp[CompW-1:0];
    it.value = v;
    it.average = avg;
    it.first_element = first;
    it.last_element = last;
    send_item(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_threshold(logic [ThreshW-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    skip_thr = v;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h80000000;
          1: return 32'h7fffffff;
          2: return 32'h0;
          3: return 32'hffffffff;
          default: return 32'h1;
        endcase
      end
      1: return $urandom_range(0, 1) ? $urandom_range(0, 20) : -$urandom_range(0, 20);
      5: return $urandom_range(0, 1) ? $urandom_range(0, 65535) << 4
                                     : -($urandom_range(0, 65535) << 4);
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      out_ch.ready <= 1'b0;
      hold_ack <= hold_req;
      hold_cycles <= 400;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= $urandom_range(0, 99) >= rx_idle_pct;
    end
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction kind=%0d result=%0d", out_ch.data.kind,
               out_ch.data.result);
        fails++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.data.kind !== exp_r.kind) begin
          $error("kind: expected %0d actual %0d", exp_r.kind, out_ch.data.kind);
          fails++;
        end
        if (out_ch.data.result !== exp_r.result) begin
          $error("result: expected %0d actual %0d", exp_r.result, out_ch.data.result);
          fails++;
        end
        if (out_ch.data.saturated !== exp_r.saturated) begin
          $error("saturated: expected %0d actual %0d", exp_r.saturated,
                 out_ch.data.saturated);
          fails++;
        end
      end
    end
  end

  // every variance is written before any score walks the table
  task automatic test_variance_init();
    for (int i = 0; i < NumComp; i++)
      send_op(ACT_VAR, i, (i % 3 == 0) ? rand_word() : 32'h0);
    send_op(ACT_VAR, 5, 32'h80000000);
    send_op(ACT_VAR, 6, 32'hfffe0000);
    send_op(ACT_VAR, 7, 32'h1);
  endtask

  task automatic test_directed();
    send_op(ACT_SCORE, 0, '0);
    send_op(ACT_WEIGHT, 0, 32'h80000000);
    send_op(ACT_WEIGHT, 127, 32'h7fffffff);
    send_op(ACT_WEIGHT, 2, 32'd6);
    send_op(ACT_WEIGHT, 3, 32'd7);
    send_op(ACT_WEIGHT, 4, -32'sd7);
    send_op(ACT_ELEM, 0, 32'h80000000, 32'h7fffffff, 1'b1, 1'b1);
    send_op(ACT_ELEM, 0, 32'h7fffffff, 32'h80000000, 1'b1, 1'b0);
    send_op(ACT_ELEM, 127, 32'h80000000, '0, 1'b0, 1'b1);
    send_op(ACT_ELEM, 2, 32'h7fffffff, 32'h00010000, 1'b1, 1'b0);
    send_op(ACT_ELEM, 3, 32'hffffffff, '0, 1'b0, 1'b0);
    send_op(ACT_ELEM, 4, 32'h00000003, '0, 1'b0, 1'b1);
    send_op(ACT_ELEM, 3, 32'h00000001, '0, 1'b0, 1'b1);
    send_op(ACT_ELEM, 9, 32'h12345678, 32'hffff8000, 1'b1, 1'b1);
    send_op(ACT_WEIGHT, 5, 32'h7fffffff);
    send_op(ACT_WEIGHT, 6, 32'h00400000);
    send_op(ACT_WEIGHT, 7, 32'h80000000);
    send_op(ACT_SCORE, 99, 32'hffffffff);
    send_op(ACT_WEIGHT, 7, 32'h0);
    send_op(ACT_SCORE, 0, '0);
  endtask

  task automatic test_random(int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_op(ACT_WEIGHT, $urandom_range(0, NumComp - 1), rand_word());
        sent++;
      end else if (r < 16) begin
        send_op(ACT_VAR, $urandom_range(0, NumComp - 1),
                $urandom_range(0, 9) < 4 ? 32'h0 : rand_word());
        sent++;
      end else if (r < 18) begin
        send_op(ACT_SCORE, $urandom_range(0, NumComp - 1), $urandom, $urandom,
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end else if (r < 22) begin
        send_op(ACT_ELEM, $urandom_range(0, NumComp - 1), rand_word(), rand_word(),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          send_op(ACT_ELEM, $urandom_range(0, NumComp - 1), rand_word(), rand_word(),
                  k == 0, k == len - 1);
        sent += len;
      end
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    hold_req = hold_req + 1;
    for (int k = 0; k < 40; k++)
      send_op(ACT_ELEM, $urandom_range(0, NumComp - 1), rand_word(), rand_word(),
              1'b1, 1'b1);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    for (int i = 0; i < NumComp; i++) begin
      weight_tab[i] = '0;
      variance_tab[i] = '0;
    end
    coord_acc = 0;
    skip_thr = ThreshReset;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_variance_init();
    test_directed();
    write_threshold(16'd0);
    test_directed();
    write_threshold(16'hffff);
    test_directed();

    tx_idle_pct = 38;
    rx_idle_pct = 84;
    test_random(480);
    write_threshold(16'd7);
    tx_idle_pct = 84;
    rx_idle_pct = 38;
    test_random(480);
    write_threshold(16'($urandom_range(0, 65535)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(420);
    test_backpressure();

    drain();
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("pca_shape_reconstruct_score_top test passed");
    end else begin
      $display("pca_shape_reconstruct_score_top test failed");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("pca_shape_reconstruct_score_top test failed");
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
rtl/psrs_pkg.sv
rtl/psrs_if.sv
rtl/psrs_divider.sv
rtl/psrs_front.sv
rtl/psrs_back.sv
rtl/pca_shape_reconstruct_score_top.sv
tb/pca_shape_reconstruct_score_top_test.sv
